FILE: rtl/core/gpnr_pkg.sv
// Shared constants, codes and beat types for the graph path node remapper.
`timescale 1ns / 1ps
`default_nettype none

package gpnr_pkg;

  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned IdxW     = $clog2(MaxNodes);
  localparam int unsigned NodeW    = 32;
  localparam int unsigned CountW   = 13;
  localparam int unsigned TblIdxW  = 12;
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic REG_REMAP_COUNT = 1'b0;
  localparam logic REG_COVER_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_WR_REMAP = 2'd0,
    OP_WR_COVER = 2'd1,
    OP_STEP     = 2'd2,
    OP_EOR      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_STEP  = 2'd0,
    KIND_KEEP  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [TblIdxW-1:0]   table_index;
    logic [31:0]          entry_node;
    logic                 entry_valid;
    logic [31:0]          step_node;
    logic                 step_reverse;
    logic [31:0]          step_start;
    logic [31:0]          step_end;
  } in_beat_t;

  typedef struct packed {
    kind_e                result_kind;
    logic [31:0]          out_node;
    logic                 out_reverse;
    logic [31:0]          out_start;
    logic [31:0]          out_end;
    logic                 last;
  } out_beat_t;

  typedef struct packed {
    logic                 valid;
    logic [NodeW-1:0]     node;
  } entry_t;

  typedef struct packed {
    logic [CountW-1:0]    remap_cnt;
    logic [CountW-1:0]    cover_cnt;
  } cnt_t;

  typedef struct packed {
    opcode_e              opcode;
    logic                 found;
    logic [NodeW-1:0]     new_node;
    logic                 step_reverse;
    logic [31:0]          step_start;
    logic [31:0]          step_end;
  } look_t;

endpackage

`default_nettype wire

FILE: rtl/core/gpnr_lookup.sv
// Remap and coverer tables with the three-stage node resolution pipeline.
`timescale 1ns / 1ps
`default_nettype none

module gpnr_lookup (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              in_valid_i,
  input  wire gpnr_pkg::in_beat_t in_beat_i,
  input  wire gpnr_pkg::cnt_t    cnt_i,
  output logic                   lk_valid_o,
  output gpnr_pkg::look_t        lk_o
);

  gpnr_pkg::entry_t remap_mem [gpnr_pkg::MaxNodes];
  gpnr_pkg::entry_t cover_mem [gpnr_pkg::MaxNodes];

  gpnr_pkg::entry_t ra_q;
  gpnr_pkg::entry_t rb_q;
  gpnr_pkg::entry_t cv_q;

  logic                        wr_in_range;
  logic                        wr_remap;
  logic                        wr_cover;
  logic [gpnr_pkg::IdxW-1:0]   wr_addr;
  logic [gpnr_pkg::IdxW-1:0]   rd_addr;
  logic [gpnr_pkg::IdxW-1:0]   via_addr;
  gpnr_pkg::entry_t            wr_entry;

  logic                        s1_valid_q;
  gpnr_pkg::opcode_e           s1_op_q;
  logic                        s1_rev_q;
  logic [31:0]                 s1_start_q;
  logic [31:0]                 s1_end_q;
  logic                        s1_in_rc_q;
  logic                        s1_in_cc_q;

  logic                        s2_valid_q;
  gpnr_pkg::opcode_e           s2_op_q;
  logic                        s2_rev_q;
  logic [31:0]                 s2_start_q;
  logic [31:0]                 s2_end_q;
  logic                        s2_in_rc_q;
  gpnr_pkg::entry_t            s2_ra_q;
  logic                        s2_cov_q;
  logic                        s2_via_rc_q;

  assign wr_in_range = (32'(in_beat_i.table_index) < gpnr_pkg::MaxNodes);
  assign wr_addr     = gpnr_pkg::IdxW'(in_beat_i.table_index);
  assign rd_addr     = in_beat_i.step_node[gpnr_pkg::IdxW-1:0];
  assign via_addr    = cv_q.node[gpnr_pkg::IdxW-1:0];
  assign wr_remap    = en_i && in_valid_i && wr_in_range &&
                       (in_beat_i.opcode == gpnr_pkg::OP_WR_REMAP);
  assign wr_cover    = en_i && in_valid_i && wr_in_range &&
                       (in_beat_i.opcode == gpnr_pkg::OP_WR_COVER);
  assign wr_entry    = '{valid: in_beat_i.entry_valid,
                         node:  gpnr_pkg::NodeW'(in_beat_i.entry_node)};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q <= remap_mem[rd_addr];
      rb_q <= remap_mem[via_addr];
    end
    if (wr_remap) begin
      remap_mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cv_q <= cover_mem[rd_addr];
    end
    if (wr_cover) begin
      cover_mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q     <= in_beat_i.opcode;
      s1_rev_q    <= in_beat_i.step_reverse;
      s1_start_q  <= in_beat_i.step_start;
      s1_end_q    <= in_beat_i.step_end;
      s1_in_rc_q  <= (in_beat_i.step_node < 32'(cnt_i.remap_cnt));
      s1_in_cc_q  <= (in_beat_i.step_node < 32'(cnt_i.cover_cnt));
      s2_op_q     <= s1_op_q;
      s2_rev_q    <= s1_rev_q;
      s2_start_q  <= s1_start_q;
      s2_end_q    <= s1_end_q;
      s2_in_rc_q  <= s1_in_rc_q;
      s2_ra_q     <= ra_q;
      s2_cov_q    <= s1_in_cc_q && cv_q.valid;
      s2_via_rc_q <= (cv_q.node < gpnr_pkg::NodeW'(cnt_i.remap_cnt));
    end
  end

  assign lk_valid_o      = s2_valid_q;
  assign lk_o.opcode     = s2_op_q;
  assign lk_o.found      = s2_in_rc_q &&
                           (s2_ra_q.valid || (s2_cov_q && s2_via_rc_q && rb_q.valid));
  assign lk_o.new_node   = s2_ra_q.valid ? s2_ra_q.node : rb_q.node;
  assign lk_o.step_reverse = s2_rev_q;
  assign lk_o.step_start = s2_start_q;
  assign lk_o.step_end   = s2_end_q;

endmodule

`default_nettype wire

FILE: rtl/core/graph_path_node_remapper_core.sv
// Top level: APB count registers, lookup pipeline, step merge and result queue.
//
//   channel   direction  handshake                 beat type
//   in        in         in_valid_i / in_stall_o   gpnr_pkg::in_beat_t
//   out       out        out_valid_o / out_stall_i gpnr_pkg::out_beat_t
//   apb       in         psel/penable/pready       32-bit count registers
//
// One input beat per cycle while in_stall_o is low; an item passes the stage 1 and stage 2
// lookup registers before its results can enter the four-entry result queue that feeds the output.
// The lookup takes three stages: remap and coverer read, remap read through the coverer,
// then resolve and merge against the held step.
// in_stall_o is high while the result queue holds more than two beats; an end of read
// with a held step puts two beats in the queue at once.
// Reset clears the counts, the held step and the queue; table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module graph_path_node_remapper_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire gpnr_pkg::in_beat_t              in_beat_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output gpnr_pkg::out_beat_t                  out_beat_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [gpnr_pkg::AddrW-1:0]      paddr,
  input  wire logic [gpnr_pkg::DataW-1:0]      pwdata,
  output logic [gpnr_pkg::DataW-1:0]           prdata,
  output logic                                 pready
);

  logic [gpnr_pkg::CountW-1:0]   remap_count_q;
  logic [gpnr_pkg::CountW-1:0]   cover_count_q;
  gpnr_pkg::cnt_t                cnt;
  logic                          cfg_wr;

  logic                          en;
  logic                          lk_valid;
  gpnr_pkg::look_t               lk;

  logic                          held_v_q,     held_v_d;
  logic [gpnr_pkg::NodeW-1:0]    held_node_q,  held_node_d;
  logic                          held_rev_q,   held_rev_d;
  logic [31:0]                   held_start_q, held_start_d;
  logic [31:0]                   held_end_q,   held_end_d;

  gpnr_pkg::out_beat_t           held_beat;
  gpnr_pkg::out_beat_t           push0;
  gpnr_pkg::out_beat_t           push1;
  logic [1:0]                    push_n;
  logic                          pop;

  gpnr_pkg::out_beat_t           fifo_q [gpnr_pkg::OutDepth];
  logic [gpnr_pkg::OutPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [gpnr_pkg::OutPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [gpnr_pkg::OutCntW-1:0]  count_q,  count_d;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_count_q <= '0;
      cover_count_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gpnr_pkg::REG_REMAP_COUNT: remap_count_q <= pwdata[gpnr_pkg::CountW-1:0];
        gpnr_pkg::REG_COVER_COUNT: cover_count_q <= pwdata[gpnr_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gpnr_pkg::REG_REMAP_COUNT: prdata = gpnr_pkg::DataW'(remap_count_q);
      gpnr_pkg::REG_COVER_COUNT: prdata = gpnr_pkg::DataW'(cover_count_q);
      default:                   prdata = '0;
    endcase
  end

  assign cnt.remap_cnt = (32'(remap_count_q) > gpnr_pkg::MaxNodes) ?
                         gpnr_pkg::CountW'(gpnr_pkg::MaxNodes) : remap_count_q;
  assign cnt.cover_cnt = (32'(cover_count_q) > gpnr_pkg::MaxNodes) ?
                         gpnr_pkg::CountW'(gpnr_pkg::MaxNodes) : cover_count_q;

  assign en         = (count_q <= gpnr_pkg::OutCntW'(gpnr_pkg::OutDepth - 2));
  assign in_stall_o = !en;

  gpnr_lookup u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .cnt_i      (cnt),
    .lk_valid_o (lk_valid),
    .lk_o       (lk)
  );

  assign held_beat = '{result_kind: gpnr_pkg::KIND_STEP,
                       out_node:    32'(held_node_q),
                       out_reverse: held_rev_q,
                       out_start:   held_start_q,
                       out_end:     held_end_q,
                       last:        1'b1};

  always_comb begin
    held_v_d     = held_v_q;
    held_node_d  = held_node_q;
    held_rev_d   = held_rev_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    push0        = held_beat;
    push1        = '{result_kind: gpnr_pkg::KIND_KEEP, out_node: '0, out_reverse: 1'b0,
                     out_start: '0, out_end: '0, last: 1'b1};
    push_n       = 2'd0;
    if (en && lk_valid) begin
      unique case (lk.opcode)
        gpnr_pkg::OP_STEP: begin
          if (lk.found) begin
            if (held_v_q && (held_node_q == lk.new_node) &&
                (held_rev_q == lk.step_reverse)) begin
              if (lk.step_end > held_end_q) begin
                held_end_d = lk.step_end;
              end
            end else begin
              if (held_v_q) begin
                push_n = 2'd1;
              end
              held_v_d     = 1'b1;
              held_node_d  = lk.new_node;
              held_rev_d   = lk.step_reverse;
              held_start_d = lk.step_start;
              held_end_d   = lk.step_end;
            end
          end
        end
        gpnr_pkg::OP_EOR: begin
          if (held_v_q) begin
            push0.last = 1'b0;
            push_n     = 2'd2;
          end else begin
            push0  = '{result_kind: gpnr_pkg::KIND_EMPTY, out_node: '0, out_reverse: 1'b0,
                       out_start: '0, out_end: '0, last: 1'b1};
            push_n = 2'd1;
          end
          held_v_d     = 1'b0;
          held_node_d  = '0;
          held_rev_d   = 1'b0;
          held_start_d = '0;
          held_end_d   = '0;
        end
        gpnr_pkg::OP_WR_REMAP, gpnr_pkg::OP_WR_COVER: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_v_q <= 1'b0;
    end else begin
      held_v_q <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_node_q  <= held_node_d;
    held_rev_q   <= held_rev_d;
    held_start_q <= held_start_d;
    held_end_q   <= held_end_d;
  end

  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + gpnr_pkg::OutPtrW'(push_n);
    rd_ptr_d = rd_ptr_q + gpnr_pkg::OutPtrW'(pop);
    count_d  = count_q + gpnr_pkg::OutCntW'(push_n) - gpnr_pkg::OutCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + gpnr_pkg::OutPtrW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= gpnr_pkg::OutCntW'(gpnr_pkg::OutDepth))
    else $error("result queue overflow");

  a_eor_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && lk_valid && (lk.opcode == gpnr_pkg::OP_EOR)) |=> !held_v_q)
    else $error("held step survives end of read");

  a_pair_only_on_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == 2'd2) |-> (held_v_q && (lk.opcode == gpnr_pkg::OP_EOR)))
    else $error("two results from an item other than end of read");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gpnr_pkg::OutPtrW'(wr_ptr_q - rd_ptr_q) == gpnr_pkg::OutPtrW'(count_q))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for graph_path_node_remapper_core: table loads, path steps, merges.
`timescale 1ns / 1ps

module tb;
  import gpnr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned NumPhases = 6;
  localparam logic [AddrW-1:0] AddrRemapCount = {REG_REMAP_COUNT, 2'b00};
  localparam logic [AddrW-1:0] AddrCoverCount = {REG_COVER_COUNT, 2'b00};
  localparam int unsigned PhaseRemap [NumPhases] = '{40, 0, 4096, 8191, 24, 200};
  localparam int unsigned PhaseCover [NumPhases] = '{24, 0, 4096, 0, 8191, 100};
  localparam int unsigned PhaseItems [NumPhases] = '{250, 100, 300, 250, 250, 200};

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  class path_remap_scoreboard;
    bit [31:0]       remap_node [MaxNodes];
    bit              remap_ok [MaxNodes];
    bit              remap_wr [MaxNodes];
    bit [31:0]       cover_node [MaxNodes];
    bit              cover_ok [MaxNodes];
    bit              cover_wr [MaxNodes];
    logic [CountW-1:0] remap_cnt;
    logic [CountW-1:0] cover_cnt;
    bit              held_valid;
    logic [31:0]     held_node;
    logic            held_rev;
    logic [31:0]     held_start;
    logic [31:0]     held_end;
    out_beat_t       expected_q [$];
    int unsigned     errors;
    int unsigned     n_in;
    int unsigned     n_out;
    int unsigned     n_merged;
    int unsigned     n_dropped;
    int unsigned     n_reads;

    function new();
      remap_cnt = '0;
      cover_cnt = '0;
      held_valid = 1'b0;
      held_node = '0;
      held_rev = 1'b0;
      held_start = '0;
      held_end = '0;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_merged = 0;
      n_dropped = 0;
      n_reads = 0;
    endfunction

    function int unsigned eff(logic [CountW-1:0] c);
      if (c > MaxNodes) return MaxNodes;
      return int'(c);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function out_beat_t mk(kind_e k, logic [31:0] node, logic rev, logic [31:0] st,
                           logic [31:0] en, logic last);
      out_beat_t r;
      r.result_kind = k;
      r.out_node = node;
      r.out_reverse = rev;
      r.out_start = st;
      r.out_end = en;
      r.last = last;
      return r;
    endfunction

    function bit resolve(logic [31:0] old, output logic [31:0] nu);
      int unsigned rc;
      int unsigned cc;
      logic [31:0] via;
      rc = eff(remap_cnt);
      cc = eff(cover_cnt);
      nu = '0;
      if (old >= rc) return 1'b0;
      if (remap_ok[old[IdxW-1:0]]) begin
        nu = remap_node[old[IdxW-1:0]];
        return 1'b1;
      end
      if (old >= cc || !cover_ok[old[IdxW-1:0]]) return 1'b0;
      via = cover_node[old[IdxW-1:0]];
      if (via >= rc || !remap_ok[via[IdxW-1:0]]) return 1'b0;
      nu = remap_node[via[IdxW-1:0]];
      return 1'b1;
    endfunction

    // true when resolving this id touches only written entries
    function bit readable(logic [31:0] old);
      int unsigned rc;
      int unsigned cc;
      logic [31:0] via;
      rc = eff(remap_cnt);
      cc = eff(cover_cnt);
      if (old >= rc) return 1'b1;
      if (!remap_wr[old[IdxW-1:0]]) return 1'b0;
      if (remap_ok[old[IdxW-1:0]] || old >= cc) return 1'b1;
      if (!cover_wr[old[IdxW-1:0]]) return 1'b0;
      if (!cover_ok[old[IdxW-1:0]]) return 1'b1;
      via = cover_node[old[IdxW-1:0]];
      if (via >= rc) return 1'b1;
      return remap_wr[via[IdxW-1:0]];
    endfunction

    function void note(in_beat_t b);
      logic [31:0] nu;
      n_in++;
      case (b.opcode)
        OP_WR_REMAP: begin
          remap_node[b.table_index] = b.entry_node;
          remap_ok[b.table_index] = b.entry_valid;
          remap_wr[b.table_index] = 1'b1;
        end
        OP_WR_COVER: begin
          cover_node[b.table_index] = b.entry_node;
          cover_ok[b.table_index] = b.entry_valid;
          cover_wr[b.table_index] = 1'b1;
        end
        OP_STEP: begin
          if (!resolve(b.step_node, nu)) begin
            n_dropped++;
          end else if (held_valid && held_node == nu && held_rev == b.step_reverse) begin
            if (b.step_end > held_end) held_end = b.step_end;
            n_merged++;
          end else begin
            if (held_valid)
              expected_q = {expected_q, mk(KIND_STEP, held_node, held_rev, held_start,
                                           held_end, 1'b1)};
            held_valid = 1'b1;
            held_node = nu;
            held_rev = b.step_reverse;
            held_start = b.step_start;
            held_end = b.step_end;
          end
        end
        OP_EOR: begin
          n_reads++;
          if (held_valid) begin
            expected_q = {expected_q, mk(KIND_STEP, held_node, held_rev, held_start,
                                         held_end, 1'b0)};
            expected_q = {expected_q, mk(KIND_KEEP, '0, 1'b0, '0, '0, 1'b1)};
          end else begin
            expected_q = {expected_q, mk(KIND_EMPTY, '0, 1'b0, '0, '0, 1'b1)};
          end
          held_valid = 1'b0;
          held_node = '0;
          held_rev = 1'b0;
          held_start = '0;
          held_end = '0;
        end
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check(out_beat_t got);
      out_beat_t want;
      n_out++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, got);
        return;
      end
      want = expected_q.pop_front();
      cmp("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      cmp("out_node", want.out_node, got.out_node);
      cmp("out_reverse", 32'(want.out_reverse), 32'(got.out_reverse));
      cmp("out_start", want.out_start, got.out_start);
      cmp("out_end", want.out_end, got.out_end);
      cmp("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  in_beat_t          in_beat;
  logic              out_valid;
  logic              out_stall;
  out_beat_t         out_beat;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  path_remap_scoreboard sb;
  idle_mode_e        idle_mode;
  logic [31:0]       node_ids [$];
  int unsigned       cycles;

  graph_path_node_remapper_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned send_pct();
    case (idle_mode)
      IDLE_SEND: return 68;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned recv_pct();
    case (idle_mode)
      IDLE_RECV: return 68;
      IDLE_BOTH: return 6;
      default:   return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct());
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check(out_beat);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_beat_t rnd_beat(opcode_e op);
    in_beat_t b;
    b.opcode = op;
    b.table_index = TblIdxW'($urandom);
    b.entry_node = $urandom;
    b.entry_valid = 1'($urandom);
    b.step_node = $urandom;
    b.step_reverse = 1'($urandom);
    b.step_start = $urandom;
    b.step_end = $urandom;
    return b;
  endfunction

  function automatic in_beat_t mk_entry(opcode_e op, int unsigned idx, logic ok,
                                        logic [31:0] node);
    in_beat_t b;
    b = rnd_beat(op);
    b.table_index = TblIdxW'(idx);
    b.entry_valid = ok;
    b.entry_node = node;
    return b;
  endfunction

  function automatic in_beat_t mk_step(logic [31:0] node, logic rev, logic [31:0] st,
                                       logic [31:0] en);
    in_beat_t b;
    b = rnd_beat(OP_STEP);
    b.step_node = node;
    b.step_reverse = rev;
    b.step_start = st;
    b.step_end = en;
    return b;
  endfunction

  function automatic logic [31:0] rnd_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'($urandom_range(0, 255));
    if (r < 30) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic int unsigned pick_index();
    if (node_ids.size() > 0 && $urandom_range(0, 9) < 7)
      return int'(node_ids[$urandom_range(0, node_ids.size() - 1)][IdxW-1:0]);
    return $urandom_range(0, MaxNodes - 1);
  endfunction

  function automatic logic [31:0] pick_node(logic [31:0] prev, bit have_prev);
    int unsigned rc;
    int unsigned r;
    logic [31:0] cand;
    rc = sb.eff(sb.remap_cnt);
    r = $urandom_range(0, 99);
    if (have_prev && r < 40 && sb.readable(prev)) return prev;
    if (r < 88 && node_ids.size() > 0) begin
      cand = node_ids[$urandom_range(0, node_ids.size() - 1)];
      if (sb.readable(cand)) return cand;
    end
    if (r >= 95) return 32'(rc);
    cand = $urandom;
    if (cand < rc) cand = cand + rc;
    return cand;
  endfunction

  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(0, 99) < send_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note(b);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read(input logic [AddrW-1:0] addr, output logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_counts(input int unsigned rc, input int unsigned cc);
    logic [DataW-1:0] rd;
    reg_write(AddrRemapCount, DataW'(rc));
    sb.remap_cnt = CountW'(rc);
    reg_write(AddrCoverCount, DataW'(cc));
    sb.cover_cnt = CountW'(cc);
    reg_read(AddrRemapCount, rd);
    sb.cmp("remap_count readback", 32'(rc), rd);
    reg_read(AddrCoverCount, rd);
    sb.cmp("coverer_count readback", 32'(cc), rd);
  endtask

  task automatic put_remap(input int unsigned idx);
    logic [31:0] nu;
    if ($urandom_range(0, 99) < 85) nu = 32'(1000 + $urandom_range(0, 5));
    else nu = $urandom;
    if (!sb.remap_wr[idx]) node_ids = {node_ids, 32'(idx)};
    send_beat(mk_entry(OP_WR_REMAP, idx, 1'($urandom_range(0, 3) != 0), nu));
  endtask

  task automatic put_cover(input int unsigned idx);
    int unsigned r;
    logic [31:0] via;
    r = $urandom_range(0, 99);
    if (r < 70 && node_ids.size() > 0) via = node_ids[$urandom_range(0, node_ids.size() - 1)];
    else if (r < 85) via = $urandom;
    else via = 32'($urandom_range(0, 63));
    send_beat(mk_entry(OP_WR_COVER, idx, 1'($urandom_range(0, 9) < 7), via));
  endtask

  task automatic load_tables();
    int unsigned rc;
    int unsigned covers;
    rc = sb.eff(sb.remap_cnt);
    covers = 0;
    if (rc == 0) begin
      repeat (6) put_remap($urandom_range(0, MaxNodes - 1));
    end else if (rc <= 48) begin
      for (int unsigned i = 0; i < rc; i++) put_remap(i);
    end else begin
      put_remap(0);
      put_remap(rc - 1);
      repeat (46) put_remap($urandom_range(0, rc - 1));
    end
    foreach (node_ids[i]) begin
      if (covers < 40 && $urandom_range(0, 9) < 5) begin
        put_cover(int'(node_ids[i][IdxW-1:0]));
        covers++;
      end
    end
    put_cover(MaxNodes - 1);
    put_cover($urandom_range(0, MaxNodes - 1));
  endtask

  task automatic run_directed();
    send_beat(mk_entry(OP_WR_REMAP, 0, 1'b1, 32'd100));
    send_beat(mk_entry(OP_WR_REMAP, 1, 1'b1, 32'd100));
    send_beat(mk_entry(OP_WR_REMAP, 2, 1'b0, 32'd0));
    send_beat(mk_entry(OP_WR_REMAP, 3, 1'b1, 32'd200));
    send_beat(mk_entry(OP_WR_REMAP, 4, 1'b0, 32'd0));
    send_beat(mk_entry(OP_WR_REMAP, 5, 1'b0, 32'd0));
    send_beat(mk_entry(OP_WR_REMAP, 6, 1'b1, 32'hFFFF_FFFF));
    send_beat(mk_entry(OP_WR_REMAP, 7, 1'b0, 32'd0));
    send_beat(mk_entry(OP_WR_COVER, 2, 1'b1, 32'd3));
    send_beat(mk_entry(OP_WR_COVER, 4, 1'b1, 32'd7));
    send_beat(mk_entry(OP_WR_COVER, 5, 1'b1, 32'd9));
    send_beat(mk_entry(OP_WR_COVER, 7, 1'b0, 32'd0));
    for (int unsigned i = 0; i < 8; i++) node_ids = {node_ids, 32'(i)};
    send_beat(mk_step(32'd0, 1'b0, 32'd0, 32'd10));
    send_beat(mk_step(32'd1, 1'b0, 32'd5, 32'hFFFF_FFFF));
    send_beat(mk_step(32'd0, 1'b0, 32'd7, 32'd3));
    send_beat(mk_step(32'd2, 1'b0, 32'd20, 32'd30));
    send_beat(mk_step(32'd3, 1'b1, 32'd40, 32'd50));
    send_beat(mk_step(32'd4, 1'b0, 32'd1, 32'd2));
    send_beat(mk_step(32'd5, 1'b1, 32'd1, 32'd2));
    send_beat(mk_step(32'd7, 1'b0, 32'd1, 32'd2));
    send_beat(mk_step(32'd8, 1'b0, 32'd1, 32'd2));
    send_beat(mk_step(32'hFFFF_FFFF, 1'b1, 32'd1, 32'd2));
    send_beat(mk_step(32'd6, 1'b0, 32'hFFFF_FFFF, 32'd0));
    send_beat(rnd_beat(OP_EOR));
    send_beat(rnd_beat(OP_EOR));
  endtask

  task automatic run_reads(input int unsigned n);
    int unsigned sent;
    int unsigned steps;
    int unsigned idx;
    logic [31:0] node;
    logic [31:0] prev_node;
    logic rev;
    logic prev_rev;
    bit have_prev;
    sent = 0;
    prev_node = '0;
    prev_rev = 1'b0;
    while (sent < n) begin
      steps = $urandom_range(0, 9);
      have_prev = 1'b0;
      repeat (steps) begin
        if ($urandom_range(0, 99) < 8) begin
          idx = pick_index();
          if ($urandom_range(0, 1) == 0) put_remap(idx);
          else put_cover(idx);
          sent++;
        end
        node = pick_node(prev_node, have_prev);
        if (have_prev && node == prev_node && $urandom_range(0, 9) < 8) rev = prev_rev;
        else rev = 1'($urandom);
        send_beat(mk_step(node, rev, rnd_offset(), rnd_offset()));
        sent++;
        prev_node = node;
        prev_rev = rev;
        have_prev = 1'b1;
      end
      send_beat(rnd_beat(OP_EOR));
      sent++;
    end
  endtask

  idle_mode_e phase_mode [NumPhases];

  initial begin
    sb = new();
    cycles = 0;
    phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
    idle_mode = IDLE_NONE;
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    out_stall <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_counts(8, 8);
    run_directed();
    for (int unsigned p = 0; p < NumPhases; p++) begin
      wait_quiet();
      idle_mode = IDLE_NONE;
      set_counts(PhaseRemap[p], PhaseCover[p]);
      idle_mode = phase_mode[p];
      load_tables();
      run_reads(PhaseItems[p]);
    end
    wait_quiet();

    $display("Covered %0d input beats in %0d reads: %0d steps merged, %0d dropped.",
             sb.n_in, sb.n_reads, sb.n_merged, sb.n_dropped);
    $display("Checked %0d result beats over 7 count settings and four idle patterns.",
             sb.n_out);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: graph_path_node_remapper_core.f
rtl/core/gpnr_pkg.sv
rtl/core/gpnr_lookup.sv
rtl/core/graph_path_node_remapper_core.sv
tb/tb.sv
